### hw/rtl/sm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_pkg
// Constants, word types and control structs shared by the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

   typedef logic [7:0][31:0] sm3_words_type;

   localparam logic [31:0] T_EARLY    = 32'h79cc4519;
   localparam logic [31:0] T_LATE     = 32'h7a879d8a;
   localparam logic [31:0] T_LATE_R16 = {T_LATE[15:0], T_LATE[31:16]};
   localparam logic [31:0] PAD_MARKER = {8'h80, 24'h000000};

   // element 0 (word A) is the rightmost entry
   localparam sm3_words_type SM3_IV = {
      32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
      32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
   };

   localparam int unsigned ROUNDS   = 64;
   localparam int unsigned ROUND_W  = $clog2(ROUNDS);
   localparam int unsigned BLOCK_W  = 16;
   localparam int unsigned LAST_EARLY_ROUND = 15;

   typedef struct packed {
      logic load;
      logic step;
      logic early;
      logic t_switch;
   } sm3_round_ctl_type;

   typedef struct packed {
      logic shift;
      logic load;
   } sm3_sched_ctl_type;

   function automatic logic [31:0] rotl9(input logic [31:0] v);
      rotl9 = {v[22:0], v[31:23]};
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] v);
      p0 = v ^ {v[22:0], v[31:23]} ^ {v[14:0], v[31:15]};
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] v);
      p1 = v ^ {v[16:0], v[31:17]} ^ {v[8:0], v[31:9]};
   endfunction

endpackage

### hw/rtl/sm3_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_channels
// Valid/ready channel interfaces for message requests and digest results.
// ----------------------------------------------------------------------------
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  byte_count;
   logic        final_word;

   modport source (output valid, message_word, byte_count, final_word, input ready);
   modport sink   (input valid, message_word, byte_count, final_word, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        digest_last;

   modport source (output valid, digest_word, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

### hw/rtl/sm3_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_sched
// Block buffer and message expansion as a sixteen-word sliding window.
// ----------------------------------------------------------------------------
module sm3_sched
   import sm3_pkg::*;
(
   input  logic              clock,
   input  sm3_sched_ctl_type ctl,
   input  logic [31:0]       push_word,
   output logic [31:0]       w0,
   output logic [31:0]       w4
);

   logic [BLOCK_W-1:0][31:0] win_ff;
   logic [31:0]              expand;
   logic [31:0]              w13;
   logic [31:0]              w3;

   assign w13    = win_ff[13];
   assign w3     = win_ff[3];
   assign expand = p1(win_ff[0] ^ win_ff[7] ^ {w13[16:0], w13[31:17]})
                 ^ {w3[24:0], w3[31:25]} ^ win_ff[10];

   assign w0 = win_ff[0];
   assign w4 = win_ff[4];

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         for (int i = 0; i < BLOCK_W - 1; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[BLOCK_W-1] <= ctl.load ? push_word : expand;
      end
   end

endmodule

### hw/rtl/sm3_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_round
// Working registers A to H and the shared compression round.
// ----------------------------------------------------------------------------
module sm3_round
   import sm3_pkg::*;
(
   input  logic              clock,
   input  sm3_round_ctl_type ctl,
   input  sm3_words_type     cv,
   input  logic [31:0]       w0,
   input  logic [31:0]       w4,
   output sm3_words_type     round_next
);

   sm3_words_type work_ff;
   logic [31:0]   tconst_ff;
   logic [31:0]   tconst_in;
   logic [31:0]   a12, sum1, ss1, ss2, ff, gg, tt1, tt2;

   always_comb begin
      a12  = {work_ff[0][19:0], work_ff[0][31:20]};
      sum1 = a12 + work_ff[4] + tconst_ff;
      ss1  = {sum1[24:0], sum1[31:25]};
      ss2  = ss1 ^ a12;
      if (ctl.early) begin
         ff = work_ff[0] ^ work_ff[1] ^ work_ff[2];
         gg = work_ff[4] ^ work_ff[5] ^ work_ff[6];
      end else begin
         ff = (work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2])
            | (work_ff[1] & work_ff[2]);
         gg = (work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]);
      end
      tt1 = ff + work_ff[3] + ss2 + (w0 ^ w4);
      tt2 = gg + work_ff[7] + ss1 + w0;

      round_next[0] = tt1;
      round_next[1] = work_ff[0];
      round_next[2] = rotl9(work_ff[1]);
      round_next[3] = work_ff[2];
      round_next[4] = p0(tt2);
      round_next[5] = work_ff[4];
      round_next[6] = {work_ff[5][12:0], work_ff[5][31:13]};
      round_next[7] = work_ff[6];

      // constant kept pre-rotated by the round index
      if (ctl.t_switch) begin
         tconst_in = T_LATE_R16;
      end else begin
         tconst_in = {tconst_ff[30:0], tconst_ff[31]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         work_ff   <= cv;
         tconst_ff <= T_EARLY;
      end else if (ctl.step) begin
         work_ff   <= round_next;
         tconst_ff <= tconst_in;
      end
   end

endmodule

### hw/rtl/sm3_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_hash_engine
// Streaming SM3 hash engine: 32-bit message requests in, 256-bit digest out.
// ----------------------------------------------------------------------------
// A request carrying a non-final word is taken while the engine is idle. Every
// sixteenth word stored, padding included, starts a compression, one round
// per cycle through the single round unit, with the message expansion worked
// out alongside in the sliding window; req_ready is low meanwhile. A final
// word adds the padding words, one or two compressions, and eight digest
// words of output, word A first, after which the engine returns to the
// initial value. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sm3_hash_engine
   import sm3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   sm3_req_if.sink      req_chan,
   sm3_rsp_if.source    rsp_chan
);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_COMPRESS = 4'b0010,
      ST_PAD      = 4'b0100,
      ST_OUTPUT   = 4'b1000
   } sm3_state_type;

   sm3_state_type       state_ff, state_in;
   logic [3:0]          wp_ff, wp_in;
   logic [63:0]         bitlen_ff, bitlen_in;
   logic                marker_ff, marker_in;
   logic                hi_ff, hi_in;
   logic                done_ff, done_in;
   logic                pad_ff, pad_in;
   logic [ROUND_W-1:0]  round_ff, round_in;
   logic [2:0]          out_idx_ff, out_idx_in;
   sm3_words_type       cv_ff, cv_in;

   sm3_round_ctl_type   rctl;
   sm3_sched_ctl_type   sctl;
   sm3_words_type       round_next;
   logic [31:0]         w0, w4;
   logic                push;
   logic [31:0]         push_word;
   logic [2:0]          count;
   logic [31:0]         last_word;
   logic                req_acc, rsp_acc;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_acc = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_OUTPUT);
   assign rsp_chan.digest_word = cv_ff[out_idx_ff];
   assign rsp_chan.digest_last = (out_idx_ff == 3'd7);

   always_comb begin
      count = (req_chan.byte_count > 3'd4) ? 3'd4 : req_chan.byte_count;
      case (count)
         3'd0:    last_word = PAD_MARKER;
         3'd1:    last_word = {req_chan.message_word[31:24], 8'h80, 16'h0000};
         3'd2:    last_word = {req_chan.message_word[31:16], 8'h80, 8'h00};
         3'd3:    last_word = {req_chan.message_word[31:8], 8'h80};
         default: last_word = req_chan.message_word;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      bitlen_in  = bitlen_ff;
      marker_in  = marker_ff;
      hi_in      = hi_ff;
      done_in    = done_ff;
      pad_in     = pad_ff;
      round_in   = round_ff;
      out_idx_in = out_idx_ff;
      cv_in      = cv_ff;
      push       = 1'b0;
      push_word  = '0;
      rctl       = '0;
      sctl       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!req_chan.final_word) begin
                  if (count != 3'd0) begin
                     bitlen_in = bitlen_ff + 64'd32;
                     push      = 1'b1;
                     push_word = req_chan.message_word;
                  end
               end else begin
                  bitlen_in = bitlen_ff + {58'd0, count, 3'b000};
                  push      = 1'b1;
                  push_word = last_word;
                  marker_in = (count == 3'd4);
                  pad_in    = 1'b1;
                  hi_in     = 1'b0;
                  done_in   = 1'b0;
               end
            end
         end
         ST_PAD: begin
            push = 1'b1;
            if (marker_ff) begin
               push_word = PAD_MARKER;
               marker_in = 1'b0;
            end else if (wp_ff == 4'd14) begin
               push_word = bitlen_ff[63:32];
               hi_in     = 1'b1;
            end else if (wp_ff == 4'd15 && hi_ff) begin
               push_word = bitlen_ff[31:0];
               done_in   = 1'b1;
            end
         end
         ST_COMPRESS: begin
            rctl.step     = 1'b1;
            rctl.early    = (round_ff <= ROUND_W'(LAST_EARLY_ROUND));
            rctl.t_switch = (round_ff == ROUND_W'(LAST_EARLY_ROUND));
            sctl.shift    = 1'b1;
            round_in      = round_ff + 1'b1;
            if (round_ff == ROUND_W'(ROUNDS - 1)) begin
               cv_in = cv_ff ^ round_next;
               if (done_ff) begin
                  state_in = ST_OUTPUT;
               end else if (pad_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUTPUT: begin
            if (rsp_acc) begin
               out_idx_in = out_idx_ff + 1'b1;
               if (out_idx_ff == 3'd7) begin
                  cv_in     = SM3_IV;
                  bitlen_in = '0;
                  wp_in     = '0;
                  pad_in    = 1'b0;
                  done_in   = 1'b0;
                  hi_in     = 1'b0;
                  marker_in = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (push) begin
         sctl.shift = 1'b1;
         sctl.load  = 1'b1;
         wp_in      = wp_ff + 1'b1;
         if (wp_ff == 4'd15) begin
            state_in  = ST_COMPRESS;
            rctl.load = 1'b1;
            round_in  = '0;
         end else if (pad_in) begin
            state_in = ST_PAD;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wp_ff      <= '0;
         bitlen_ff  <= '0;
         marker_ff  <= 1'b0;
         hi_ff      <= 1'b0;
         done_ff    <= 1'b0;
         pad_ff     <= 1'b0;
         round_ff   <= '0;
         out_idx_ff <= '0;
         cv_ff      <= SM3_IV;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         bitlen_ff  <= bitlen_in;
         marker_ff  <= marker_in;
         hi_ff      <= hi_in;
         done_ff    <= done_in;
         pad_ff     <= pad_in;
         round_ff   <= round_in;
         out_idx_ff <= out_idx_in;
         cv_ff      <= cv_in;
      end
   end

   sm3_sched u_sched (
      .clock     (clock),
      .ctl       (sctl),
      .push_word (push_word),
      .w0        (w0),
      .w4        (w4)
   );

   sm3_round u_round (
      .clock      (clock),
      .ctl        (rctl),
      .cv         (cv_ff),
      .w0         (w0),
      .w4         (w4),
      .round_next (round_next)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while digest pending");

   a_compress_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPRESS && round_ff == ROUND_W'(ROUNDS - 1))
      |=> state_ff != ST_COMPRESS)
      else $error("compression ran past last round");

   a_block_full: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_COMPRESS) |-> wp_ff == 4'd0)
      else $error("compression started on partial block");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_acc && rsp_chan.digest_last)
      |=> (bitlen_ff == 64'd0 && wp_ff == 4'd0 && cv_ff == SM3_IV))
      else $error("state not returned to initial value");

endmodule

### dv/sm3_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_digest_checker
// Watches the request and digest channels of the SM3 hash engine. Every
// accepted request goes through a local SM3 predictor: word gathering,
// padding, the 64-bit length and the compression. Each final word yields
// eight expected digest words. Every accepted digest word is compared with
// the oldest expected one, and failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module sm3_digest_checker
   import sm3_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sm3_req_if   req_mon,
   sm3_rsp_if   rsp_mon,
   output int   error_total,
   output int   digests_owed
);

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } digest_beat_type;

   logic [31:0]     hash_state [8];
   logic [31:0]     msg_block [16];
   logic [3:0]      fill_index;
   logic [63:0]     msg_bits;
   digest_beat_type digest_queue [$];
   digest_beat_type want;

   function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
      int unsigned k;
      k = n % 32;
      if (k == 0) return v;
      return (v << k) | (v >> (32 - k));
   endfunction

   function automatic logic [31:0] mix_p0(input logic [31:0] v);
      return v ^ rol32(v, 9) ^ rol32(v, 17);
   endfunction

   function automatic logic [31:0] mix_p1(input logic [31:0] v);
      return v ^ rol32(v, 15) ^ rol32(v, 23);
   endfunction

   function automatic void restart_hash();
      for (int k = 0; k < 8; k++) hash_state[k] = SM3_IV[k];
      for (int k = 0; k < 16; k++) msg_block[k] = '0;
      fill_index = '0;
      msg_bits = '0;
   endfunction

   function automatic void fold_block();
      logic [31:0] ex [68];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] tj, a12, s1, s2, ff, gg, t1, t2;
      int r;
      for (r = 0; r < 16; r++) ex[r] = msg_block[r];
      for (r = 16; r < 68; r++)
         ex[r] = mix_p1(ex[r-16] ^ ex[r-9] ^ rol32(ex[r-3], 15))
               ^ rol32(ex[r-13], 7) ^ ex[r-6];
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (r = 0; r < 64; r++) begin
         tj  = (r < 16) ? T_EARLY : T_LATE;
         a12 = rol32(a, 12);
         s1  = rol32(a12 + e + rol32(tj, r), 7);
         s2  = s1 ^ a12;
         if (r < 16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
         end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
         end
         t1 = ff + d + s2 + (ex[r] ^ ex[r+4]);
         t2 = gg + h + s1 + ex[r];
         d = c;
         c = rol32(b, 9);
         b = a;
         a = t1;
         h = g;
         g = rol32(f, 19);
         f = e;
         e = mix_p0(t2);
      end
      hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
      hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
   endfunction

   function automatic void append_word(input logic [31:0] w);
      msg_block[fill_index] = w;
      fill_index = fill_index + 4'd1;
      if (fill_index == 4'd0) fold_block();
   endfunction

   function automatic void absorb_request(input logic [31:0] w, input logic [2:0] count,
                                          input logic last);
      int unsigned     nbytes;
      logic [31:0]     keep;
      digest_beat_type beat;
      nbytes = (count > 3'd4) ? 4 : count;
      if (!last) begin
         // empty non-final requests are dropped; short ones count as full
         if (nbytes == 0) return;
         msg_bits += 64'd32;
         append_word(w);
         return;
      end
      msg_bits += 64'(nbytes * 8);
      if (nbytes == 4) begin
         append_word(w);
         append_word(PAD_MARKER);
      end else begin
         keep = (nbytes == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nbytes));
         append_word((w & keep) | (32'h80 << (24 - 8 * nbytes)));
      end
      while (fill_index != 4'd14) append_word(32'h0);
      append_word(msg_bits[63:32]);
      append_word(msg_bits[31:0]);
      for (int k = 0; k < 8; k++) begin
         beat.word    = hash_state[k];
         beat.last    = (k == 7);
         digest_queue = {digest_queue, beat};
      end
      restart_hash();
   endfunction

   function automatic void flag_error(input string msg);
      error_total++;
      if (error_total <= 10) $display("%t %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart_hash();
         digest_queue.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            absorb_request(req_mon.message_word, req_mon.byte_count, req_mon.final_word);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (digest_queue.size() == 0) begin
               flag_error($sformatf("unexpected digest word %08h last %0b",
                                    rsp_mon.digest_word, rsp_mon.digest_last));
            end else begin
               want = digest_queue.pop_front();
               if (rsp_mon.digest_word !== want.word || rsp_mon.digest_last !== want.last)
                  flag_error($sformatf("digest mismatch: expected %08h last %0b, got %08h last %0b",
                                       want.word, want.last,
                                       rsp_mon.digest_word, rsp_mon.digest_last));
            end
         end
      end
      digests_owed = digest_queue.size();
   end

endmodule

### dv/sm3_hash_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_hash_engine_tb
// Drives message requests into the SM3 hash engine in random bursts while
// the digest side stalls on its own pattern. A short directed set covers
// empty, partial, oversized and ignored byte counts and a message whose
// padding fits its last block exactly; random messages of varied length
// follow. The checker beside the engine predicts and compares the digests.
// ----------------------------------------------------------------------------
module sm3_hash_engine_tb;

   logic clock = 1'b0;
   logic reset;
   int   error_total;
   int   digests_owed;
   int   burst_left = 0;
   int   stall_left = 0;
   int   stall_mode = 0;
   int   items_sent = 0;
   int   n;
   int   i;
   logic [2:0] cnt;

   sm3_req_if req_chan ();
   sm3_rsp_if rsp_chan ();

   sm3_hash_engine DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sm3_digest_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .error_total  (error_total),
      .digests_owed (digests_owed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: ready pattern changes mode each time stall_left runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: begin
            rsp_chan.ready <= 1'b1;
         end
         1: begin
            rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         end
         2: begin
            rsp_chan.ready <= (stall_left % 4 == 0);
         end
         default: begin
            rsp_chan.ready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   task automatic send_request(input logic [31:0] w, input logic [2:0] c, input logic f);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid        <= 1'b1;
      req_chan.message_word <= w;
      req_chan.byte_count   <= c;
      req_chan.final_word   <= f;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.message_word <= '0;
      req_chan.byte_count   <= '0;
      req_chan.final_word   <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: final byte counts 0..4, 6 and 7, dropped, short and oversized non-final requests
      send_request(32'hffffffff, 3'd0, 1'b1);
      send_request(32'hffffffff, 3'd1, 1'b1);
      send_request(32'hffffffff, 3'd2, 1'b1);
      send_request(32'hffffffff, 3'd3, 1'b1);
      send_request(32'hffffffff, 3'd4, 1'b1);
      send_request(32'h00000000, 3'd7, 1'b1);
      send_request(32'h12345678, 3'd0, 1'b0);
      send_request(32'habcdef01, 3'd2, 1'b0);
      send_request(32'h00000000, 3'd5, 1'b0);
      send_request(32'hffffffff, 3'd6, 1'b1);
      // padding and length fill the first block exactly
      for (i = 0; i < 13; i++) send_request($urandom, 3'd4, 1'b0);
      send_request(32'h00ffffff, 3'd3, 1'b1);

      while (items_sent < 350) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 18);
         for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) send_request($urandom, 3'd0, 1'b0);
            cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : 3'd4;
            send_request($urandom, cnt, 1'b0);
            items_sent++;
         end
         send_request($urandom, 3'($urandom_range(0, 7)), 1'b1);
         items_sent++;
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (digests_owed != 0) @(posedge clock);
      repeat (160) @(posedge clock);
      if (error_total == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
